>>> src/scdp_pkg.sv
// Package: shared types, codes and constants of the container directory parser.
`default_nettype none

package scdp_pkg;

  // Default limit on the number of directory entries parsed per image.
  localparam int unsigned MaxEntriesDefault = 255;
  // Default depth of the queue between the front and back parts.
  localparam int unsigned QueueDepthDefault = 4;

  // Fixed header layout.
  localparam logic [31:0] HeaderBytes = 32'd9;
  localparam logic [11:0] EntryBytes  = 12'd14;
  localparam logic [3:0]  SigLen      = 4'd8;
  localparam logic [3:0]  EntryLast   = 4'd13;

  // Signature "SINCLAIR", byte zero in bits 7:0.
  localparam logic [63:0] SigBytes = 64'h5249_414C_434E_4953;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ENTRY  = 2'd0,
    ST_OK     = 2'd1,
    ST_BADSIG = 2'd2,
    ST_TRUNC  = 2'd3
  } status_e;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ENTRIES,
    PH_SKIP
  } phase_e;

  // Kind of work handed from the front to the back.
  typedef enum logic [2:0] {
    K_ENTRY,
    K_ENTRY_LAST,
    K_SUMMARY,
    K_BADSIG,
    K_TRUNC
  } kind_e;

  // One queued command: everything the back needs to form its words.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  entry_index;
    logic [63:0] file_name;
    logic [7:0]  extension;
    logic [15:0] start_address;
    logic [15:0] length_bytes;
    logic [7:0]  sector_count;
    logic [23:0] file_offset;
    logic [23:0] payload_total;
    logic [7:0]  file_total;
  } cmd_t;

  // One result word.
  typedef struct packed {
    status_e     status;
    logic [7:0]  entry_index;
    logic [63:0] file_name;
    logic [7:0]  extension;
    logic [15:0] start_address;
    logic [15:0] length_bytes;
    logic [7:0]  sector_count;
    logic [23:0] file_offset;
    logic [23:0] payload_total;
    logic [7:0]  file_total;
    logic        done_res;
  } res_t;

endpackage

`default_nettype wire

>>> src/scdp_if.sv
// Interfaces: the byte input channel and the result output channel.
`default_nettype none

interface scdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface scdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  entry_index;
  logic [63:0] file_name;
  logic [7:0]  extension;
  logic [15:0] start_address;
  logic [15:0] length_bytes;
  logic [7:0]  sector_count;
  logic [23:0] file_offset;
  logic [23:0] payload_total;
  logic [7:0]  file_total;
  logic        done_res;

  modport source (
    output valid, output status, output entry_index, output file_name, output extension,
    output start_address, output length_bytes, output sector_count, output file_offset,
    output payload_total, output file_total, output done_res, input ready
  );
  modport sink (
    input valid, input status, input entry_index, input file_name, input extension,
    input start_address, input length_bytes, input sector_count, input file_offset,
    input payload_total, input file_total, input done_res, output ready
  );
endinterface

`default_nettype wire

>>> src/sinclair_container_directory_parser.sv
// Top level: container directory parser with front, command queue and back.
//
//   Channel   Dir  Handshake         Payload
//   in_i      in   valid/ready       data_byte, first_byte
//   res_o     out  valid/ready       status, entry fields, totals, done_res
//   cfg       in   cfg_we_i          cfg_wdata_i (image size)
//
// One byte is taken per cycle while the command queue is not full; the front updates counters and a shift register.
// Each word leaves through a registered output once its command has passed through the queue.
// The entry that closes the directory gives two words: the entry word, then the summary word.
// Input ready drops only while the command queue is full. Reset is asynchronous,
// active low, and needs no clearing pass.
`default_nettype none

module sinclair_container_directory_parser
  import scdp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i,
  scdp_in_if.sink     in_i,
  scdp_out_if.source  res_o
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  scdp_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  scdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  scdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

>>> src/scdp_front.sv
// Front part: accepts image bytes, tracks the header and directory, queues commands.
`default_nettype none

module scdp_front
  import scdp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i,
  scdp_in_if.sink     in_i,
  input  wire         q_full_i,
  output logic        push_o,
  output cmd_t        push_cmd_o
);

  localparam logic [7:0] Limit = 8'(MAX_ENTRIES);

  phase_e       phase_q, phase_d;
  logic [31:0]  image_size_q;
  logic [3:0]   hdr_pos_q, hdr_pos_d;
  logic [7:0]   files_q, files_d;
  logic [7:0]   cur_q, cur_d;
  logic [3:0]   ebp_q, ebp_d;
  logic [103:0] asm_q, asm_d;
  logic [23:0]  ro_q, ro_d;
  logic [11:0]  dir_end_q, dir_end_d;

  logic         accept;
  logic [11:0]  dir_len;
  logic [7:0]   limit_now;
  logic [7:0]   files_cap;
  logic [23:0]  ro_next;
  logic [7:0]   cur_next;

  // A free queue slot is all the front needs to take a byte.
  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // Directory length and entry limit from the count byte.
  assign dir_len   = 12'd9 + EntryBytes * {4'd0, in_i.data_byte};
  assign limit_now = (in_i.data_byte > Limit) ? Limit : in_i.data_byte;
  assign files_cap = (files_q > Limit) ? Limit : files_q;
  assign ro_next   = ro_q + {8'd0, in_i.data_byte, 8'd0};
  assign cur_next  = cur_q + 8'd1;

  // Next state and queued command.
  always_comb begin
    phase_d    = phase_q;
    hdr_pos_d  = hdr_pos_q;
    files_d    = files_q;
    cur_d      = cur_q;
    ebp_d      = ebp_q;
    asm_d      = asm_q;
    ro_d       = ro_q;
    dir_end_d  = dir_end_q;
    push_o     = 1'b0;
    push_cmd_o = '0;

    if (accept) begin
      // A first-byte flag restarts parsing; a tiny image is rejected at once.
      if (in_i.first_byte) begin
        phase_d   = PH_HEADER;
        hdr_pos_d = 4'd0;
        files_d   = 8'd0;
        cur_d     = 8'd0;
        ebp_d     = 4'd0;
        ro_d      = 24'd0;
        dir_end_d = 12'd0;
        if (image_size_q < HeaderBytes) begin
          phase_d         = PH_SKIP;
          push_o          = 1'b1;
          push_cmd_o.kind = K_TRUNC;
        end
      end

      if (!(in_i.first_byte && (image_size_q < HeaderBytes))) begin
        case (phase_d)
          PH_HEADER: begin
            if (hdr_pos_d < SigLen) begin
              // Signature check, one byte at a time.
              if (in_i.data_byte != SigBytes[{hdr_pos_d[2:0], 3'b000} +: 8]) begin
                phase_d         = PH_SKIP;
                push_o          = 1'b1;
                push_cmd_o.kind = K_BADSIG;
              end else begin
                hdr_pos_d = hdr_pos_d + 4'd1;
              end
            end else begin
              // File count byte.
              files_d = in_i.data_byte;
              if ({20'd0, dir_len} > image_size_q) begin
                phase_d         = PH_SKIP;
                push_o          = 1'b1;
                push_cmd_o.kind = K_TRUNC;
              end else begin
                dir_end_d = dir_len;
                ro_d      = {12'd0, dir_len};
                if (limit_now == 8'd0) begin
                  phase_d         = PH_SKIP;
                  push_o          = 1'b1;
                  push_cmd_o.kind = K_SUMMARY;
                end else begin
                  phase_d = PH_ENTRIES;
                end
              end
            end
          end
          PH_ENTRIES: begin
            if (ebp_q < EntryLast) begin
              // Gather entry bytes; byte zero ends up in bits 7:0.
              asm_d = {in_i.data_byte, asm_q[103:8]};
              ebp_d = ebp_q + 4'd1;
            end else begin
              // Sector count byte completes the entry.
              push_o                   = 1'b1;
              push_cmd_o.kind          = K_ENTRY;
              push_cmd_o.entry_index   = cur_q;
              push_cmd_o.file_name     = asm_q[63:0];
              push_cmd_o.extension     = asm_q[71:64];
              push_cmd_o.start_address = asm_q[87:72];
              push_cmd_o.length_bytes  = asm_q[103:88];
              push_cmd_o.sector_count  = in_i.data_byte;
              push_cmd_o.file_offset   = ro_q;
              ro_d                     = ro_next;
              cur_d                    = cur_next;
              ebp_d                    = 4'd0;
              if (cur_next >= files_cap) begin
                phase_d                  = PH_SKIP;
                push_cmd_o.kind          = K_ENTRY_LAST;
                push_cmd_o.payload_total = ro_next - {12'd0, dir_end_q};
                push_cmd_o.file_total    = cur_next;
              end
            end
          end
          default: begin
            // Idle or skipping: bytes are dropped.
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      image_size_q <= 32'd0;
      hdr_pos_q    <= 4'd0;
      files_q      <= 8'd0;
      cur_q        <= 8'd0;
      ebp_q        <= 4'd0;
      ro_q         <= 24'd0;
      dir_end_q    <= 12'd0;
    end else begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      files_q   <= files_d;
      cur_q     <= cur_d;
      ebp_q     <= ebp_d;
      ro_q      <= ro_d;
      dir_end_q <= dir_end_d;
      if (cfg_we_i) begin
        image_size_q <= cfg_wdata_i;
      end
    end
  end

  // Entry assembly shift register carries payload only.
  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
  end

endmodule

`default_nettype wire

>>> src/scdp_queue.sv
// Command queue between the front and back parts.
`default_nettype none

module scdp_queue
  import scdp_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  cmd_t  push_cmd_i,
  output logic  full_o,
  output logic  head_valid_o,
  output cmd_t  head_cmd_o,
  input  wire   pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push;
  logic          do_pop;

  assign full_o       = (count_q == CW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> src/scdp_back.sv
// Back part: turns queued commands into result words in an output register.
`default_nettype none

module scdp_back
  import scdp_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         head_valid_i,
  input  cmd_t        head_cmd_i,
  output logic        pop_o,
  scdp_out_if.source  res_o
);

  logic out_valid_q, out_valid_d;
  logic half_q, half_d;
  res_t res_q, res_d;
  logic can_load;

  assign can_load = !out_valid_q || res_o.ready;

  // Word formation: an entry that closes the directory yields two words.
  always_comb begin
    out_valid_d = out_valid_q;
    half_d      = half_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    if (can_load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        res_d = '0;
        case (head_cmd_i.kind)
          K_ENTRY, K_ENTRY_LAST: begin
            if (head_cmd_i.kind == K_ENTRY_LAST && half_q) begin
              res_d.status        = ST_OK;
              res_d.payload_total = head_cmd_i.payload_total;
              res_d.file_total    = head_cmd_i.file_total;
              res_d.done_res      = 1'b1;
              half_d              = 1'b0;
              pop_o               = 1'b1;
            end else begin
              res_d.status        = ST_ENTRY;
              res_d.entry_index   = head_cmd_i.entry_index;
              res_d.file_name     = head_cmd_i.file_name;
              res_d.extension     = head_cmd_i.extension;
              res_d.start_address = head_cmd_i.start_address;
              res_d.length_bytes  = head_cmd_i.length_bytes;
              res_d.sector_count  = head_cmd_i.sector_count;
              res_d.file_offset   = head_cmd_i.file_offset;
              if (head_cmd_i.kind == K_ENTRY_LAST) begin
                half_d = 1'b1;
              end else begin
                pop_o = 1'b1;
              end
            end
          end
          K_SUMMARY: begin
            res_d.status        = ST_OK;
            res_d.payload_total = head_cmd_i.payload_total;
            res_d.file_total    = head_cmd_i.file_total;
            res_d.done_res      = 1'b1;
            pop_o               = 1'b1;
          end
          K_BADSIG: begin
            res_d.status   = ST_BADSIG;
            res_d.done_res = 1'b1;
            pop_o          = 1'b1;
          end
          default: begin
            res_d.status   = ST_TRUNC;
            res_d.done_res = 1'b1;
            pop_o          = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = res_q.status;
  assign res_o.entry_index   = res_q.entry_index;
  assign res_o.file_name     = res_q.file_name;
  assign res_o.extension     = res_q.extension;
  assign res_o.start_address = res_q.start_address;
  assign res_o.length_bytes  = res_q.length_bytes;
  assign res_o.sector_count  = res_q.sector_count;
  assign res_o.file_offset   = res_q.file_offset;
  assign res_o.payload_total = res_q.payload_total;
  assign res_o.file_total    = res_q.file_total;
  assign res_o.done_res      = res_q.done_res;

endmodule

`default_nettype wire
